// File: sv/sequenced_hex_record_decoder_defines.svh
// Assertion macros used by the RTL (shrd_ctrl only).
`ifndef SEQUENCED_HEX_RECORD_DECODER_DEFINES_SVH
`define SEQUENCED_HEX_RECORD_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define SHRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHRD_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHRD_ASSERT(lbl, clk, rst, prop, msg)
`define SHRD_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// File: sv/shrd_pkg.sv
package shrd_pkg;

   localparam int unsigned BYTE_W = 8;

   typedef struct packed {
      logic accept_byte;
      logic load_rd;
      logic step_idx;
      logic commit_id;
      logic err_sel;
   } cmd_type;

   typedef struct packed {
      logic rec_end;
      logic id_dup;
      logic id_next;
      logic idx_last;
   } status_type;

   // 0..15 for a hex digit, 16 otherwise
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61) + 5'd10;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41) + 5'd10;
      end else begin
         v = 5'd16;
      end
      return v;
   endfunction

   function automatic logic [BYTE_W-1:0] decode_pair(input logic [BYTE_W-1:0] first,
                                                     input logic [BYTE_W-1:0] second);
      logic [4:0] hi;
      logic [4:0] lo;
      logic [BYTE_W-1:0] r;
      hi = hex_value(first);
      lo = hex_value(second);
      if (hi[4]) begin
         r = '0;
      end else if (lo[4]) begin
         r = {4'd0, hi[3:0]};
      end else begin
         r = {hi[3:0], lo[3:0]};
      end
      return r;
   endfunction

endpackage

// File: sv/shrd_datapath.sv
module shrd_datapath #(
   parameter int unsigned PAYLOAD_BYTES = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  shrd_pkg::cmd_type      cmd,
   output shrd_pkg::status_type   status,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int unsigned RECORD_BYTES = 1 + 2 * PAYLOAD_BYTES;
   localparam int unsigned POS_W = $clog2(RECORD_BYTES);
   localparam int unsigned SLOT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        cur_id_ff, cur_id_in;
   logic [7:0]        prev_id_ff, prev_id_in;
   logic [7:0]        held_ff, held_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [7:0]        rd_ff;
   logic [7:0]        store [PAYLOAD_BYTES];
   logic [SLOT_W-1:0] slot_wr;
   logic              wr_en;

   assign status.rec_end  = (pos_ff == POS_W'(RECORD_BYTES - 1));
   assign status.id_dup   = (cur_id_ff == prev_id_ff);
   assign status.id_next  = (prev_id_ff != 8'hFF) && (cur_id_ff == prev_id_ff + 8'd1);
   assign status.idx_last = (idx_ff == SLOT_W'(PAYLOAD_BYTES - 1));

   assign slot_wr = SLOT_W'((pos_ff >> 1) - POS_W'(1));
   assign wr_en   = cmd.accept_byte && !pos_ff[0] && (pos_ff != '0);

   always_comb begin
      pos_in     = pos_ff;
      cur_id_in  = cur_id_ff;
      held_in    = held_ff;
      prev_id_in = prev_id_ff;
      idx_in     = idx_ff;
      if (cmd.accept_byte) begin
         pos_in = status.rec_end ? '0 : pos_ff + POS_W'(1);
         if (pos_ff == '0) begin
            cur_id_in = req_tdata;
         end else if (pos_ff[0]) begin
            held_in = req_tdata;
         end
      end
      if (cmd.commit_id) begin
         prev_id_in = cur_id_ff;
         idx_in     = '0;
      end else if (cmd.step_idx) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         cur_id_ff  <= '0;
         prev_id_ff <= '0;
         held_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         cur_id_ff  <= cur_id_in;
         prev_id_ff <= prev_id_in;
         held_ff    <= held_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[slot_wr] <= shrd_pkg::decode_pair(held_ff, req_tdata);
      end
      if (cmd.load_rd) begin
         rd_ff <= store[idx_ff];
      end
   end

   assign rsp_tdata = cmd.err_sel ? 8'd0 : rd_ff;
   assign rsp_tuser = cmd.err_sel;
   assign rsp_tlast = cmd.err_sel || status.idx_last;

endmodule

// File: sv/shrd_ctrl.sv
`include "sequenced_hex_record_decoder_defines.svh"

module shrd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  shrd_pkg::status_type  status,
   output shrd_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_RECV = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SHOW = 3'd2;
   localparam logic [2:0] ST_ERR  = 3'd3;
   localparam logic [2:0] ST_HALT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accepted;

   assign req_tready = (state_ff == ST_RECV) || (state_ff == ST_HALT);
   assign rsp_tvalid = (state_ff == ST_SHOW) || (state_ff == ST_ERR);
   assign accepted   = req_tvalid && req_tready;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.err_sel     = (state_ff == ST_ERR);
      case (state_ff)
         ST_RECV: begin
            cmd.accept_byte = accepted;
            if (accepted && status.rec_end && !status.id_dup) begin
               if (status.id_next) begin
                  cmd.commit_id = 1'b1;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_rd = 1'b1;
            state_in    = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_tready) begin
               if (status.idx_last) begin
                  state_in = ST_RECV;
               end else begin
                  cmd.step_idx = 1'b1;
                  state_in     = ST_LOAD;
               end
            end
         end
         ST_ERR: begin
            if (rsp_tready) begin
               state_in = ST_HALT;
            end
         end
         ST_HALT: begin
            state_in = ST_HALT;
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   `SHRD_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid), "ready during result")
   `SHRD_ASSERT(a_halt_sticks, clock, reset, (state_ff == ST_HALT) |=> (state_ff == ST_HALT), "left halt")
   `SHRD_ASSERT(a_burst_end, clock, reset, (state_ff == ST_SHOW && rsp_tready && status.idx_last) |=> (state_ff == ST_RECV && status.idx_last), "burst end")
   `SHRD_ASSERT_NORST(a_reset_recv, clock, $past(reset) |-> (state_ff == ST_RECV), "not idle after reset")

endmodule

// File: sv/sequenced_hex_record_decoder.sv
// Sequenced hex record decoder.
// req_* : input stream, one raw byte per item (req_tdata[7:0]). Records are
//         one ID byte followed by 2*PAYLOAD_BYTES hex characters.
// rsp_* : result stream. rsp_tdata[7:0] is the decoded byte (0 on error),
//         rsp_tuser is 1 for a sequence error, rsp_tlast marks the final
//         byte of a record and the error item.
// Rate: record bytes are taken one per cycle while no burst or error item
//   is pending. A record whose ID is the last ID plus one then yields a burst
//   of PAYLOAD_BYTES items, each read from the payload store into rd_ff and
//   then shown on rsp_*, during which req_tready is low. A duplicate ID is
//   dropped with no output. A bad ID gives one error item, after which
//   input is taken and discarded until reset.
// Order: the error item is offered in the cycle after the final record byte.
// Reset: synchronous, active high; last ID returns to 0, record position to 0.
// Stall: a held rsp_tready low freezes the current item on rsp_* and keeps
//   req_tready low until the burst is delivered.
module sequenced_hex_record_decoder #(
   parameter int unsigned PAYLOAD_BYTES = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] status
   output logic       rsp_tlast
);

   shrd_pkg::cmd_type    cmd;
   shrd_pkg::status_type status;

   shrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   shrd_datapath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// File: tb/sv/sequenced_hex_record_decoder_tb.sv
module sequenced_hex_record_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAYLOAD_LEN = 9;
   localparam int RECORD_LEN  = 1 + 2 * PAYLOAD_LEN;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       seq_err;
      logic       tail;
   } decoded_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tuser;           // [0] status
   logic       rsp_tlast;

   // decoder state as the testbench sees it
   int               rec_pos = 0;
   logic [7:0]       last_id = 8'h00;
   logic [7:0]       rec_id = 8'h00;
   logic [7:0]       first_char = 8'h00;
   logic [7:0]       pair_bytes [PAYLOAD_LEN];
   logic             seq_halted = 1'b0;
   decoded_item_type decoded_q [$];

   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         error_count = 0;
   int         records_sent = 0;
   int         results_seen = 0;
   int         quiet_cycles = 0;
   logic [7:0] id_sent = 8'h00;

   sequenced_hex_record_decoder #(
      .PAYLOAD_BYTES(PAYLOAD_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bit 4 set: not a hex digit
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         return {1'b0, c[3:0]};
      end
      if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         return {1'b0, c[3:0] + 4'd9};
      end
      return 5'h10;
   endfunction

   function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] hi;
      logic [4:0] lo;
      hi = nibble_of(a);
      lo = nibble_of(b);
      if (hi[4]) begin
         return 8'h00;
      end
      if (lo[4]) begin
         return {4'h0, hi[3:0]};
      end
      return {hi[3:0], lo[3:0]};
   endfunction

   function automatic void follow_byte(input logic [7:0] b);
      decoded_item_type item;
      if (seq_halted) begin
         return;
      end
      if (rec_pos == 0) begin
         rec_id = b;
      end else if (rec_pos % 2 == 1) begin
         first_char = b;
      end else begin
         pair_bytes[(rec_pos - 2) / 2] = pair_value(first_char, b);
      end
      rec_pos++;
      if (rec_pos < RECORD_LEN) begin
         return;
      end
      rec_pos = 0;
      if (rec_id == last_id) begin
         return;
      end
      if (last_id != 8'hFF && rec_id == last_id + 8'd1) begin
         for (int k = 0; k < PAYLOAD_LEN; k++) begin
            item.data    = pair_bytes[k];
            item.seq_err = 1'b0;
            item.tail    = (k == PAYLOAD_LEN - 1);
            decoded_q.push_back(item);
         end
         last_id = rec_id;
      end else begin
         item.data    = 8'h00;
         item.seq_err = 1'b1;
         item.tail    = 1'b1;
         decoded_q.push_back(item);
         seq_halted = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t mismatch on %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      decoded_item_type want;
      if (!reset && req_tvalid && req_tready) begin
         follow_byte(req_tdata);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, 8'h00);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch("out_byte", rsp_tdata, want.data);
            end
            if (rsp_tuser !== want.seq_err) begin
               report_mismatch("status", 8'(rsp_tuser), 8'(want.seq_err));
            end
            if (rsp_tlast !== want.tail) begin
               report_mismatch("last_of_run", 8'(rsp_tlast), 8'(want.tail));
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("sequenced_hex_record_decoder test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [7:0] pick_char(input int noise_pct);
      logic [7:0] d;
      if ($urandom_range(99) < noise_pct) begin
         return 8'($urandom_range(255));
      end
      d = 8'($urandom_range(15));
      if (d < 10) begin
         return 8'h30 + d;
      end
      return ($urandom_range(1) ? 8'h57 : 8'h37) + d;
   endfunction

   task automatic send_record(input logic [7:0] id, input int noise_pct);
      send_byte(id);
      repeat (2 * PAYLOAD_LEN) send_byte(pick_char(noise_pct));
      records_sent++;
   endtask

   task automatic send_text_record(input logic [7:0] id, input string s);
      send_byte(id);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
      records_sent++;
   endtask

   task automatic wait_drained();
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // last ID starts at 0, so ID 0 is dropped
   task automatic test_first_duplicate();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      repeat (2 * PAYLOAD_LEN - 2) send_byte(pick_char(100));
      records_sent++;
   endtask

   // both cases, non-hex first/second, whitespace, signs, prefixes, range edges
   task automatic test_hex_pairs();
      send_byte(8'h01);
      send_byte("0"); send_byte("9");
      send_byte("a"); send_byte("f");
      send_byte("A"); send_byte("F");
      send_byte("F"); send_byte("a");
      send_byte("g"); send_byte("1");
      send_byte("7"); send_byte(" ");
      send_byte("+"); send_byte("5");
      send_byte("5"); send_byte(8'h00);
      send_byte(8'hFF); send_byte("5");
      records_sent++;
      send_text_record(8'h02, "3x/09:@AaG`Ff`g90x");
      id_sent = 8'h02;
   endtask

   // half a record, then silence until all results are in: nothing may come out
   task automatic test_partial_record();
      send_byte(8'h03);
      repeat (PAYLOAD_LEN) send_byte(pick_char(10));
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      repeat (PAYLOAD_LEN) send_byte(pick_char(10));
      records_sent++;
      id_sent = 8'h03;
   endtask

   task automatic test_random_records(input int count);
      int noise;
      for (int r = 0; r < count; r++) begin
         noise = ($urandom_range(99) < 20) ? 60 : 8;
         if ($urandom_range(99) < 15) begin
            send_record(id_sent, noise);
         end else begin
            id_sent = id_sent + 8'd1;
            send_record(id_sent, noise);
         end
      end
   endtask

   // an ID that skips one: error item, then everything is dropped
   task automatic test_sequence_error();
      send_record(id_sent + 8'd2, 5);
      repeat (RECORD_LEN + 6) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(36, 72);
      test_first_duplicate();
      test_hex_pairs();
      test_partial_record();
      test_random_records(4);

      set_idling(72, 36);
      test_random_records(4);

      set_idling(0, 0);
      test_random_records(2);
      test_sequence_error();

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d records, checked %0d result items", records_sent, results_seen);
      $display("covered hex decoding, duplicates, a paused partial record and the halt on a lost ID");
      if (error_count == 0) begin
         $display("sequenced_hex_record_decoder test passed");
      end else begin
         $display("sequenced_hex_record_decoder test failed");
      end
      $finish;
   end

endmodule
